// File: design/m4tu_pkg.sv
`default_nettype none
package m4tu_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 4;
  localparam int ELEMS     = 16;
  localparam int PROD_W    = 2 * DATA_W;
  // exact sum of four shifted products, with headroom for the carries
  localparam int ACC_W     = PROD_W - FRAC_BITS + 2;

  localparam logic signed [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_LOAD_CUR  = 3'd0,
    CMD_LOAD_OPD  = 3'd1,
    CMD_MUL       = 3'd2,
    CMD_TRANSPOSE = 3'd3,
    CMD_SCALE     = 3'd4,
    CMD_TRANSLATE = 3'd5,
    CMD_READ      = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_COPY,
    S_READ
  } state_t;

  typedef enum logic [2:0] {
    B_OPD,
    B_X,
    B_Y,
    B_Z,
    B_ONE
  } bsel_t;

  typedef struct packed {
    logic             issue;
    logic [IDX_W-1:0] a_addr;
    bsel_t            b_sel;
    logic [IDX_W-1:0] b_addr;
    logic             term_first;
    logic             term_last;
    logic [IDX_W-1:0] dest;
    logic             to_tmp;
    logic             load_cur;
    logic             load_opd;
    logic             transpose;
    logic             copy;
    logic             start;
  } dp_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < ACC_W'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/m4tu_ctrl.sv
`default_nettype none
module m4tu_ctrl
  import m4tu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       cmd,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [IDX_W-1:0]      out_index,
  output logic                  last,
  output dp_cmd_t               dp_cmd,
  input  wire logic             pipe_busy
);

  state_t           state, state_next;
  cmd_t             op;
  logic [IDX_W-1:0] elem;
  logic [1:0]       term;
  logic             mac_done;
  logic             in_accept;
  logic             read_accept;
  cmd_t             in_cmd;

  assign in_cmd      = cmd_t'(cmd);
  assign in_accept   = in_valid && in_ready;
  assign read_accept = out_valid && out_ready;

  always_comb begin
    case (op)
      CMD_MUL:       mac_done = (term == 2'd3) && (elem == IDX_W'(ELEMS - 1));
      CMD_TRANSLATE: mac_done = (term == 2'd3) && (elem == IDX_W'(2));
      CMD_SCALE:     mac_done = (elem == IDX_W'(11));
      default:       mac_done = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_MUL, CMD_SCALE, CMD_TRANSLATE: state_next = S_MAC;
            CMD_READ:                          state_next = S_READ;
            default:                           state_next = S_IDLE;
          endcase
        end
      end
      S_MAC: begin
        if (mac_done) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!pipe_busy) state_next = (op == CMD_MUL) ? S_COPY : S_IDLE;
      end
      S_COPY: state_next = S_IDLE;
      S_READ: begin
        if (read_accept && (elem == IDX_W'(ELEMS - 1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    dp_cmd    = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_index = elem;
    last      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready           = 1'b1;
        dp_cmd.load_cur    = in_valid && (in_cmd == CMD_LOAD_CUR);
        dp_cmd.load_opd    = in_valid && (in_cmd == CMD_LOAD_OPD);
        dp_cmd.transpose   = in_valid && (in_cmd == CMD_TRANSPOSE);
        dp_cmd.start       = in_valid;
      end
      S_MAC: begin
        dp_cmd.issue = 1'b1;
        case (op)
          CMD_MUL: begin
            dp_cmd.a_addr     = {term, elem[1:0]};
            dp_cmd.b_sel      = B_OPD;
            dp_cmd.b_addr     = {elem[3:2], term};
            dp_cmd.term_first = (term == 2'd0);
            dp_cmd.term_last  = (term == 2'd3);
            dp_cmd.dest       = elem;
            dp_cmd.to_tmp     = 1'b1;
          end
          CMD_TRANSLATE: begin
            // the fourth term is the old offset times one
            dp_cmd.a_addr = {term, elem[1:0]};
            case (term)
              2'd0:    dp_cmd.b_sel = B_X;
              2'd1:    dp_cmd.b_sel = B_Y;
              2'd2:    dp_cmd.b_sel = B_Z;
              default: dp_cmd.b_sel = B_ONE;
            endcase
            dp_cmd.term_first = (term == 2'd0);
            dp_cmd.term_last  = (term == 2'd3);
            dp_cmd.dest       = {2'b11, elem[1:0]};
          end
          default: begin
            dp_cmd.a_addr = elem;
            case (elem[3:2])
              2'd0:    dp_cmd.b_sel = B_X;
              2'd1:    dp_cmd.b_sel = B_Y;
              default: dp_cmd.b_sel = B_Z;
            endcase
            dp_cmd.term_first = 1'b1;
            dp_cmd.term_last  = 1'b1;
            dp_cmd.dest       = elem;
          end
        endcase
      end
      S_COPY: dp_cmd.copy = 1'b1;
      S_READ: begin
        out_valid     = 1'b1;
        dp_cmd.a_addr = elem;
        last          = (elem == IDX_W'(ELEMS - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= CMD_LOAD_CUR;
      elem  <= '0;
      term  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          elem <= '0;
          term <= '0;
          if (in_accept) op <= in_cmd;
        end
        S_MAC: begin
          if (op == CMD_SCALE) begin
            elem <= elem + IDX_W'(1);
          end else begin
            term <= term + 2'd1;
            if (term == 2'd3) elem <= elem + IDX_W'(1);
          end
        end
        S_READ: begin
          if (read_accept) elem <= elem + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken during read out");

  a_read_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("not idle after last read transaction");

  a_copy_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> !pipe_busy)
    else $error("copy before accumulator drained");

  a_copy_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (op == CMD_MUL))
    else $error("copy outside multiply");

endmodule
`default_nettype wire

// File: design/m4tu_dp.sv
`default_nettype none
module m4tu_dp
  import m4tu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  dp_cmd,
  input  wire logic [IDX_W-1:0]         elem_index,
  input  wire logic signed [DATA_W-1:0] elem_value,
  input  wire logic signed [DATA_W-1:0] coord_x,
  input  wire logic signed [DATA_W-1:0] coord_y,
  input  wire logic signed [DATA_W-1:0] coord_z,
  output logic signed [DATA_W-1:0]      rd_value,
  output logic                          pipe_busy
);

  logic signed [DATA_W-1:0] current [ELEMS];
  logic signed [DATA_W-1:0] operand [ELEMS];
  logic signed [DATA_W-1:0] tmp     [ELEMS];
  logic signed [DATA_W-1:0] cx, cy, cz;

  logic signed [DATA_W-1:0] a_val, b_val;
  logic signed [PROD_W-1:0] prod;
  logic                     s1_valid;
  logic                     s1_first;
  logic                     s1_last;
  logic [IDX_W-1:0]         s1_dest;
  logic                     s1_to_tmp;

  logic signed [ACC_W-1:0]  acc, acc_next, term_val;
  logic signed [PROD_W+1:0] prod_ext;
  logic signed [DATA_W-1:0] result;
  logic                     wr_cur;

  assign a_val    = current[dp_cmd.a_addr];
  assign rd_value = a_val;
  assign pipe_busy = s1_valid;

  always_comb begin
    case (dp_cmd.b_sel)
      B_OPD:   b_val = operand[dp_cmd.b_addr];
      B_X:     b_val = cx;
      B_Y:     b_val = cy;
      B_Z:     b_val = cz;
      default: b_val = ONE;
    endcase
  end

  // arithmetic shift of the exact product floors toward minus infinity
  assign prod_ext = {{2{prod[PROD_W-1]}}, prod};
  assign term_val = ACC_W'(prod_ext >>> FRAC_BITS);
  assign acc_next = (s1_first ? ACC_W'(0) : acc) + term_val;
  assign result   = sat(acc_next);
  assign wr_cur   = s1_valid && s1_last && !s1_to_tmp;

  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      cx <= coord_x;
      cy <= coord_y;
      cz <= coord_z;
    end
    prod      <= a_val * b_val;
    s1_first  <= dp_cmd.term_first;
    s1_last   <= dp_cmd.term_last;
    s1_dest   <= dp_cmd.dest;
    s1_to_tmp <= dp_cmd.to_tmp;
    if (s1_valid) begin
      acc <= acc_next;
      if (s1_last && s1_to_tmp) tmp[s1_dest] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= dp_cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ELEMS; i++) begin
        current[i] <= (i % 5 == 0) ? ONE : '0;
        operand[i] <= '0;
      end
    end else begin
      if (dp_cmd.load_opd) operand[elem_index] <= elem_value;
      if (dp_cmd.load_cur) begin
        current[elem_index] <= elem_value;
      end else if (dp_cmd.transpose) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            current[c*4+r] <= current[r*4+c];
          end
        end
      end else if (dp_cmd.copy) begin
        for (int i = 0; i < ELEMS; i++) begin
          current[i] <= tmp[i];
        end
      end else if (wr_cur) begin
        current[s1_dest] <= result;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/matrix4_transform_unit.sv
// 4x4 column-major Q16.16 matrix unit
//
// input channel (in_valid / in_ready): one command per transaction with
// cmd, elem_index, elem_value and coord_x/y/z. loads and transpose finish
// in the accepting cycle; the unit is ready again the next cycle
// scale forms 12 products, translate 12, multiply 64: every product
// goes through the single 32x32 multiplier, then a registered
// accumulate-and-saturate stage. multiply results land in a scratch
// matrix and replace the current matrix in one copy cycle
// output channel (out_valid / out_ready): read out returns 16
// transactions, index 0 to 15, one per cycle while out_ready is high,
// from the cycle after the accept, last high on index 15. a stalled
// receiver holds the unit in read out; no new command is taken until
// the last transaction is accepted
// reset (rst, synchronous) makes the current matrix the identity, clears
// the operand matrix and returns the unit to idle
`default_nettype none
module matrix4_transform_unit
  import m4tu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               cmd,
  input  wire logic [IDX_W-1:0]         elem_index,
  input  wire logic signed [DATA_W-1:0] elem_value,
  input  wire logic signed [DATA_W-1:0] coord_x,
  input  wire logic signed [DATA_W-1:0] coord_y,
  input  wire logic signed [DATA_W-1:0] coord_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [IDX_W-1:0]              out_index,
  output logic signed [DATA_W-1:0]      out_value,
  output logic                          last
);

  dp_cmd_t dp_cmd;
  logic    pipe_busy;

  m4tu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .last      (last),
    .dp_cmd    (dp_cmd),
    .pipe_busy (pipe_busy)
  );

  m4tu_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .rd_value   (out_value),
    .pipe_busy  (pipe_busy)
  );

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import m4tu_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int N_ITEMS = 360;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] Q_HI  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_LO  = 32'sh8000_0000;
  localparam longint SUM_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SUM_LO = -64'sh0000_0000_8000_0000;

  typedef struct {
    logic [2:0]               op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    int unsigned              gap;
  } cmd_item_t;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
    logic                     last_flag;
  } elem_rd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic [2:0]               cmd        = '0;
  logic [IDX_W-1:0]         elem_index = '0;
  logic signed [DATA_W-1:0] elem_value = '0;
  logic signed [DATA_W-1:0] coord_x    = '0;
  logic signed [DATA_W-1:0] coord_y    = '0;
  logic signed [DATA_W-1:0] coord_z    = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic [IDX_W-1:0]         out_index;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;

  cmd_item_t pending_q[$];
  elem_rd_t  readout_q[$];
  cmd_item_t cur_item;

  logic signed [DATA_W-1:0] cur_m [ELEMS];
  logic signed [DATA_W-1:0] opd_m [ELEMS];

  int unsigned n_accepted = 0;
  int unsigned n_total    = 0;
  int unsigned n_fail     = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_cnt   = 0;
  bit          in_burst  = 1'b0;
  bit          out_burst = 1'b0;

  matrix4_transform_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_index  (out_index),
    .out_value  (out_value),
    .last       (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // exact product, arithmetic shift floors toward minus infinity
  function automatic longint qprod(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q(longint v);
    if (v > SUM_HI) return Q_HI;
    if (v < SUM_LO) return Q_LO;
    return v[DATA_W-1:0];
  endfunction

  function automatic void apply_matrix_cmd(cmd_item_t it);
    logic signed [DATA_W-1:0] tmp [ELEMS];
    longint acc;
    case (it.op)
      CMD_LOAD_CUR: cur_m[it.idx] = it.val;
      CMD_LOAD_OPD: opd_m[it.idx] = it.val;
      CMD_MUL: begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
              acc += qprod(cur_m[k*4+r], opd_m[c*4+k]);
            end
            tmp[c*4+r] = clamp_q(acc);
          end
        end
        cur_m = tmp;
      end
      CMD_TRANSPOSE: begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            tmp[c*4+r] = cur_m[r*4+c];
          end
        end
        cur_m = tmp;
      end
      CMD_SCALE: begin
        for (int r = 0; r < 4; r++) begin
          cur_m[r]   = clamp_q(qprod(cur_m[r], it.x));
          cur_m[4+r] = clamp_q(qprod(cur_m[4+r], it.y));
          cur_m[8+r] = clamp_q(qprod(cur_m[8+r], it.z));
        end
      end
      CMD_TRANSLATE: begin
        // only column 3 rows 0..2 move, element 15 stays
        for (int r = 0; r < 3; r++) begin
          acc = qprod(cur_m[r], it.x) + qprod(cur_m[4+r], it.y)
              + qprod(cur_m[8+r], it.z) + longint'(cur_m[12+r]);
          cur_m[12+r] = clamp_q(acc);
        end
      end
      CMD_READ: begin
        for (int k = 0; k < ELEMS; k++) begin
          readout_q.push_back('{IDX_W'(k), cur_m[k], k == ELEMS - 1});
        end
      end
      default: ;
    endcase
  endfunction

  // mostly small values, some extremes, some anything
  function automatic logic signed [DATA_W-1:0] rand_q();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return DATA_W'($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS);
    if (sel < 65) begin
      case ($urandom_range(0, 5))
        0: return Q_HI;
        1: return Q_LO;
        2: return '0;
        3: return Q_ONE;
        4: return -Q_ONE;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic void add_cmd(logic [2:0] op, logic [IDX_W-1:0] idx,
                                  logic signed [DATA_W-1:0] val,
                                  logic signed [DATA_W-1:0] x,
                                  logic signed [DATA_W-1:0] y,
                                  logic signed [DATA_W-1:0] z);
    cmd_item_t it;
    it.op  = op;
    it.idx = idx;
    it.val = val;
    it.x   = x;
    it.y   = y;
    it.z   = z;
    it.gap = in_burst ? 0 : $urandom_range(0, 15);
    pending_q.push_back(it);
  endfunction

  // fields that the command ignores carry junk
  function automatic void add_plain(logic [2:0] op);
    add_cmd(op, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void add_coords(logic [2:0] op, logic signed [DATA_W-1:0] x,
                                     logic signed [DATA_W-1:0] y,
                                     logic signed [DATA_W-1:0] z);
    add_cmd(op, IDX_W'($urandom), $urandom, x, y, z);
  endfunction

  function automatic void add_load(logic [2:0] op, logic [IDX_W-1:0] idx,
                                   logic signed [DATA_W-1:0] val);
    add_cmd(op, idx, val, $urandom, $urandom, $urandom);
  endfunction

  // driver: a transaction goes when valid and ready meet at the edge
  always @(posedge clk) begin : drive_proc
    int unsigned idle;
    if (rst) begin
      in_valid <= 1'b0;
      idle_cycles = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        apply_matrix_cmd(cur_item);
        n_accepted++;
      end
      idle = in_valid ? 0 : idle_cycles;
      if (pending_q.size() != 0 && idle >= pending_q[0].gap) begin
        cur_item = pending_q.pop_front();
        cmd        <= cur_item.op;
        elem_index <= cur_item.idx;
        elem_value <= cur_item.val;
        coord_x    <= cur_item.x;
        coord_y    <= cur_item.y;
        coord_z    <= cur_item.z;
        in_valid   <= 1'b1;
        idle_cycles = 0;
      end else begin
        in_valid <= 1'b0;
        idle_cycles = idle + 1;
      end
    end
  end

  // monitor: checks each read-out transaction and throttles out_ready
  always @(posedge clk) begin : monitor_proc
    elem_rd_t    exp_el;
    int unsigned stall;
    if (rst) begin
      out_ready <= 1'b0;
      stall_cnt = 0;
    end else if (out_valid && out_ready) begin
      if (readout_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected transaction: idx %0d value %0d last %0d",
                   out_index, out_value, last);
      end else begin
        exp_el = readout_q.pop_front();
        if (out_index !== exp_el.idx || out_value !== exp_el.val ||
            last !== exp_el.last_flag) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: expected idx %0d value %0d last %0d, got idx %0d value %0d last %0d",
                     exp_el.idx, exp_el.val, exp_el.last_flag,
                     out_index, out_value, last);
        end
      end
      if (last) out_burst = ($urandom_range(0, 3) == 0);
      stall = out_burst ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall_cnt = stall;
      end
    end else if (!out_ready) begin
      if (stall_cnt <= 1) out_ready <= 1'b1;
      else stall_cnt = stall_cnt - 1;
    end
  end

  initial begin : stim_proc
    int unsigned sel;
    int unsigned n;
    for (int i = 0; i < ELEMS; i++) begin
      cur_m[i] = (i % 5 == 0) ? Q_ONE : '0;
      opd_m[i] = '0;
    end

    // directed: identity read, saturating scale and translate, transpose,
    // extreme loads and indexes, multiply, the unused command code
    add_plain(CMD_READ);
    add_coords(CMD_SCALE, Q_HI, Q_LO, -Q_ONE);
    add_plain(CMD_READ);
    add_coords(CMD_SCALE, Q_HI, Q_HI, '0);
    add_coords(CMD_TRANSLATE, Q_ONE, Q_ONE, Q_ONE);
    add_plain(CMD_READ);
    add_coords(CMD_TRANSLATE, Q_LO, Q_LO, Q_LO);
    add_plain(CMD_READ);
    add_plain(CMD_TRANSPOSE);
    add_plain(CMD_READ);
    add_load(CMD_LOAD_CUR, 4'd0, Q_LO);
    add_load(CMD_LOAD_CUR, 4'd15, Q_HI);
    add_load(CMD_LOAD_OPD, 4'd0, Q_LO);
    add_load(CMD_LOAD_OPD, 4'd15, Q_HI);
    add_load(CMD_LOAD_OPD, 4'd5, -1);
    add_load(CMD_LOAD_OPD, 4'd10, Q_ONE);
    add_plain(CMD_MUL);
    add_plain(CMD_READ);
    add_plain(CMD_UNUSED);
    add_plain(CMD_READ);

    while (pending_q.size() < N_ITEMS) begin
      in_burst = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        for (int i = 0; i < ELEMS; i++) add_load(CMD_LOAD_CUR, IDX_W'(i), rand_q());
        add_plain(CMD_READ);
      end else if (sel < 35) begin
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
          add_load(CMD_LOAD_OPD, IDX_W'($urandom_range(0, 15)), rand_q());
        add_plain(CMD_MUL);
        if ($urandom_range(0, 3) != 0) add_plain(CMD_READ);
      end else begin
        add_cmd(3'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 15)), rand_q(),
                rand_q(), rand_q(), rand_q());
        if ($urandom_range(0, 2) == 0) add_plain(CMD_READ);
      end
    end
    n_total = pending_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (readout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
design/m4tu_pkg.sv
design/m4tu_ctrl.sv
design/m4tu_dp.sv
design/matrix4_transform_unit.sv
bench/tb.sv
